// File: rtl/vn_pkg.sv
// Package for the vector normaliser: shared constants and the control
// record that travels down the pipeline beside the datapath. No dependencies.
`default_nettype none

package vn_pkg;

  localparam int NumAxes = 3;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic [NumAxes-1:0]   neg;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/vn_lane.sv
// One registered step of a bit-serial square-root style search: decides one result
// bit (none if BIT < 0) by shifts, adds, a subtract and a compare. No package use.
`default_nettype none

module vn_lane #(
  parameter int WIDTH = 62,
  parameter int QW    = 16,
  parameter int BIT   = 0
) (
  input  wire logic             clk_i,
  input  wire logic [WIDTH-1:0] rem_i,
  input  wire logic [WIDTH-1:0] acc_i,
  input  wire logic [WIDTH-1:0] scl_i,
  input  wire logic [QW-1:0]    q_i,
  output logic      [WIDTH-1:0] rem_o,
  output logic      [WIDTH-1:0] acc_o,
  output logic      [WIDTH-1:0] scl_o,
  output logic      [QW-1:0]    q_o
);

  logic [WIDTH-1:0] rem_d, acc_d;
  logic [QW-1:0]    q_d;

  generate
    if (BIT >= 0) begin : g_step
      logic [WIDTH-1:0] trial;
      logic             take;
      // The trial is 2^(b+1)*q*S + 2^(2b)*S, the growth of q^2*S when bit b is set.
      assign trial = (acc_i << (BIT + 1)) + (scl_i << (2 * BIT));
      assign take  = (rem_i >= trial);
      always_comb begin
        rem_d = rem_i;
        acc_d = acc_i;
        q_d   = q_i;
        if (take) begin
          rem_d = rem_i - trial;
          acc_d = acc_i + (scl_i << BIT);
          q_d   = q_i | ({{(QW-1){1'b0}}, 1'b1} << BIT);
        end
      end
    end else begin : g_hold
      always_comb begin
        rem_d = rem_i;
        acc_d = acc_i;
        q_d   = q_i;
      end
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    acc_o <= acc_d;
    scl_o <= scl_i;
    q_o   <= q_d;
  end

endmodule

`default_nettype wire

// File: rtl/vn_merge.sv
// Output stage: joins the lane results with the signs and the zero flag and
// registers the result. Uses vn_pkg for the control record.
`default_nettype none

module vn_merge #(
  parameter int INPUT_WIDTH   = 16,
  parameter int FRACTION_BITS = 14,
  parameter int QW            = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire vn_pkg::ctl_t                   ctl_i,
  input  wire logic [QW-1:0]                  qx_i,
  input  wire logic [QW-1:0]                  qy_i,
  input  wire logic [QW-1:0]                  qz_i,
  input  wire logic [QW-1:0]                  ql_i,
  output logic                                done_o,
  output logic signed [FRACTION_BITS+1:0]     unit_x_o,
  output logic signed [FRACTION_BITS+1:0]     unit_y_o,
  output logic signed [FRACTION_BITS+1:0]     unit_z_o,
  output logic        [INPUT_WIDTH-1:0]       vec_length_o,
  output logic                                zero_vector_o
);

  localparam int UW = FRACTION_BITS + 2;

  logic [UW-1:0] ux_d, uy_d, uz_d;

  function automatic logic [UW-1:0] apply_sign(input logic [QW-1:0] q, input logic neg,
                                               input logic zero);
    logic [UW-1:0] m;
    m = {1'b0, q[FRACTION_BITS:0]};
    if (zero) begin
      return '0;
    end
    return neg ? (~m + 1'b1) : m;
  endfunction

  assign ux_d = apply_sign(qx_i, ctl_i.neg[0], ctl_i.zero);
  assign uy_d = apply_sign(qy_i, ctl_i.neg[1], ctl_i.zero);
  assign uz_d = apply_sign(qz_i, ctl_i.neg[2], ctl_i.zero);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_x_o      <= ux_d;
    unit_y_o      <= uy_d;
    unit_z_o      <= uz_d;
    vec_length_o  <= ql_i[INPUT_WIDTH-1:0];
    zero_vector_o <= ctl_i.zero;
  end

endmodule

`default_nettype wire

// File: rtl/vector3_normalizer.sv
// Vector normaliser top level: front end (magnitudes, squares, sum), the lane
// pipeline and the output stage. Depends on vn_pkg, vn_lane and vn_merge.
`default_nettype none

// A request is taken on every cycle in which start_i is high; busy_o is always
// low, so requests may follow each other in consecutive cycles. Each request
// yields one result, marked by done_o for a single cycle, once it has passed
// the front-end registers, the lane pipeline and the output register. The
// lane pipeline settles at most one result bit per stage, in all four lanes
// at once. The receiver cannot stall the block.
module vector3_normalizer #(
  parameter int INPUT_WIDTH   = 16,
  parameter int FRACTION_BITS = 14
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic signed [INPUT_WIDTH-1:0]      comp_x_i,
  input  wire logic signed [INPUT_WIDTH-1:0]      comp_y_i,
  input  wire logic signed [INPUT_WIDTH-1:0]      comp_z_i,
  output logic                                    done_o,
  output logic signed [FRACTION_BITS+1:0]         unit_x_o,
  output logic signed [FRACTION_BITS+1:0]         unit_y_o,
  output logic signed [FRACTION_BITS+1:0]         unit_z_o,
  output logic        [INPUT_WIDTH-1:0]           vec_length_o,
  output logic                                    zero_vector_o
);

  localparam int W      = INPUT_WIDTH;
  localparam int F      = FRACTION_BITS;
  localparam int SqW    = 2 * W;
  localparam int SumW   = 2 * W + 2;
  localparam int LaneW  = 2 * W + 2 * F + 2;
  localparam int QW     = (F + 1 > W) ? F + 1 : W;
  localparam int Depth  = QW;
  localparam int Lanes  = vn_pkg::NumAxes + 1;
  localparam int Lat    = Depth + 4;

  logic [W-1:0]    comp_w [vn_pkg::NumAxes];
  logic [W-1:0]    mag_q  [vn_pkg::NumAxes];
  logic [SqW-1:0]  sq_q   [vn_pkg::NumAxes];
  logic [SqW-1:0]  sq2_q  [vn_pkg::NumAxes];
  logic [SumW-1:0] sum_q;
  vn_pkg::ctl_t    ctl0_q, ctl1_q, ctl2_q;
  vn_pkg::ctl_t    ctl_pipe_q [Depth];

  logic [LaneW-1:0] rem_w [Lanes][Depth+1];
  logic [LaneW-1:0] acc_w [Lanes][Depth+1];
  logic [LaneW-1:0] scl_w [Lanes][Depth+1];
  logic [QW-1:0]    q_w   [Lanes][Depth+1];

  assign busy_o    = 1'b0;
  assign comp_w[0] = comp_x_i;
  assign comp_w[1] = comp_y_i;
  assign comp_w[2] = comp_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl0_q.valid <= start_i && !busy_o;
      ctl0_q.zero  <= (comp_x_i == '0) && (comp_y_i == '0) && (comp_z_i == '0);
      for (int a = 0; a < vn_pkg::NumAxes; a++) begin
        ctl0_q.neg[a] <= comp_w[a][W-1];
      end
      ctl1_q <= ctl0_q;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < vn_pkg::NumAxes; a++) begin
      mag_q[a]      <= comp_w[a][W-1] ? (~comp_w[a] + 1'b1) : comp_w[a];
      sq_q[a]       <= SqW'(mag_q[a]) * SqW'(mag_q[a]);
      sq2_q[a]      <= sq_q[a];
    end
    sum_q       <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  end

  genvar l, k;
  generate
    for (l = 0; l < Lanes; l++) begin : g_lane
      if (l < vn_pkg::NumAxes) begin : g_unit
        assign rem_w[l][0] = {2'b00, sq2_q[l], {(2 * F){1'b0}}};
        assign scl_w[l][0] = {{(LaneW-SumW){1'b0}}, sum_q};
      end else begin : g_root
        assign rem_w[l][0] = {{(LaneW-SumW){1'b0}}, sum_q};
        assign scl_w[l][0] = LaneW'(1);
      end
      assign acc_w[l][0] = '0;
      assign q_w[l][0]   = '0;
      for (k = 0; k < Depth; k++) begin : g_stage
        vn_lane #(
          .WIDTH (LaneW),
          .QW    (QW),
          .BIT   ((l < vn_pkg::NumAxes) ? F - k : W - 1 - k)
        ) u_lane (
          .clk_i (clk_i),
          .rem_i (rem_w[l][k]),
          .acc_i (acc_w[l][k]),
          .scl_i (scl_w[l][k]),
          .q_i   (q_w[l][k]),
          .rem_o (rem_w[l][k+1]),
          .acc_o (acc_w[l][k+1]),
          .scl_o (scl_w[l][k+1]),
          .q_o   (q_w[l][k+1])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        ctl_pipe_q[i] <= '0;
      end
    end else begin
      ctl_pipe_q[0] <= ctl2_q;
      for (int i = 1; i < Depth; i++) begin
        ctl_pipe_q[i] <= ctl_pipe_q[i-1];
      end
    end
  end

  vn_merge #(
    .INPUT_WIDTH   (W),
    .FRACTION_BITS (F),
    .QW            (QW)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl_pipe_q[Depth-1]),
    .qx_i          (q_w[0][Depth]),
    .qy_i          (q_w[1][Depth]),
    .qz_i          (q_w[2][Depth]),
    .ql_i          (q_w[3][Depth]),
    .done_o        (done_o),
    .unit_x_o      (unit_x_o),
    .unit_y_o      (unit_y_o),
    .unit_z_o      (unit_z_o),
    .vec_length_o  (vec_length_o),
    .zero_vector_o (zero_vector_o)
  );

  a_done_follows_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("result without a matching request");

  a_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && zero_vector_o |->
      unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0 && vec_length_o == '0)
    else $error("zero vector with nonzero outputs");

  a_nonzero_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !zero_vector_o |-> vec_length_o != '0)
    else $error("nonzero vector with zero length");

endmodule

`default_nettype wire
